@@ rtl/core/ksms_pkg.sv @@
`default_nettype none

package ksms_pkg;

	// Store depth and sample width.
	localparam int MAX_K       = 16;
	localparam int SAMPLE_BITS = 16;

	// Width of the rank register as seen on the configuration port.
	localparam int K_W    = 5;
	// Width of a store slot index.
	localparam int SLOT_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
	// Width of a count that can hold MAX_K itself.
	localparam int CNT_W  = $clog2(MAX_K + 1);

	typedef logic [SAMPLE_BITS-1:0] mag_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // input transaction taken this cycle
		logic cfg_write;  // rank register written this cycle
		logic scan_step;  // one entry of the rescan
		logic emit;       // load the result and clear the run
	} ksms_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;  // the item being accepted calls for a rescan
		logic scan_done;  // the current scan step covers the last kept slot
		logic out_free;   // the output register can take a result now
	} ksms_status_t;

endpackage

`default_nettype wire

@@ rtl/core/ksms_datapath.sv @@
`default_nettype none

module ksms_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [ksms_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic [ksms_pkg::K_W-1:0]      k_count,
	input  wire ksms_pkg::ksms_cmd_t           cmd,
	output ksms_pkg::ksms_status_t             status,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ksms_pkg::SAMPLE_BITS-1:0]   kth_magnitude,
	output logic                               too_few
);
	import ksms_pkg::*;

	mag_t              store_q [MAX_K];
	mag_t              largest_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  filled_q;
	logic [K_W-1:0]    k_q;
	logic [SLOT_W-1:0] idx_q;
	logic              out_valid_q;
	mag_t              out_mag_q;
	logic              out_few_q;

	logic [CNT_W-1:0]  k_use;
	logic [CNT_W-1:0]  filled_inc;
	logic              fill_mode;
	mag_t              mag;
	mag_t              scan_rd;

	// Rank in use: zero acts as one, anything above the depth as the depth.
	always_comb begin
		if (k_q == '0) begin
			k_use = CNT_W'(1);
		end else if (32'(k_q) > 32'(MAX_K)) begin
			k_use = CNT_W'(MAX_K);
		end else begin
			k_use = CNT_W'(k_q);
		end
	end

	// Two's complement magnitude; the most negative sample maps to 2^(n-1).
	assign mag        = sample[SAMPLE_BITS-1] ? (~sample + mag_t'(1)) : sample;
	assign fill_mode  = filled_q < k_use;
	assign filled_inc = filled_q + CNT_W'(1);
	assign scan_rd    = store_q[idx_q];

	assign status.need_scan = fill_mode ? (filled_inc == k_use) : (mag < largest_q);
	assign status.scan_done = ({1'b0, idx_q} == (k_use - CNT_W'(1)));
	assign status.out_free  = !out_valid_q || out_ready;

	// Magnitude store, written on fill or on replacement of the largest.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			if (fill_mode) begin
				store_q[filled_q[SLOT_W-1:0]] <= mag;
			end else if (mag < largest_q) begin
				store_q[slot_q] <= mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q       <= K_W'(1);
			largest_q <= '0;
			slot_q    <= '0;
			filled_q  <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.cfg_write) begin
				k_q       <= k_count;
				largest_q <= '0;
				slot_q    <= '0;
				filled_q  <= '0;
			end else if (cmd.emit) begin
				largest_q <= '0;
				slot_q    <= '0;
				filled_q  <= '0;
			end else if (cmd.accept) begin
				if (fill_mode) begin
					filled_q <= filled_inc;
				end
			end else if (cmd.scan_step) begin
				// Slot zero seeds the maximum; later slots replace it only when larger,
				// so ties keep the lowest slot.
				if (idx_q == '0) begin
					largest_q <= scan_rd;
					slot_q    <= '0;
				end else if (scan_rd > largest_q) begin
					largest_q <= scan_rd;
					slot_q    <= idx_q;
				end
				if (status.scan_done) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_mag_q <= fill_mode ? '0 : largest_q;
			out_few_q <= fill_mode;
		end
	end

	assign out_valid     = out_valid_q;
	assign kth_magnitude = out_mag_q;
	assign too_few       = out_few_q;

endmodule

`default_nettype wire

@@ rtl/core/ksms_ctrl.sv @@
`default_nettype none

module ksms_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   is_last,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire ksms_pkg::ksms_status_t status,
	output ksms_pkg::ksms_cmd_t         cmd
);
	import ksms_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   last_q;
	logic   accept;

	// An offered rank write takes priority over a sample in the same cycle.
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	assign cmd.accept    = accept;
	assign cmd.cfg_write = cfg_valid && cfg_ready;
	assign cmd.scan_step = (state_q == ST_SCAN);
	assign cmd.emit      = (state_q == ST_EMIT) && status.out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (status.need_scan) begin
						state_d = ST_SCAN;
					end else if (is_last) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_d = last_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				last_q <= is_last;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/kth_smallest_magnitude_select.sv @@
`default_nettype none

// K-th smallest magnitude selector.
// Samples arrive as transactions on the input channel (sample, is_last). The
// block keeps the magnitudes of the first k samples of a run and, after that,
// replaces the largest kept magnitude whenever a strictly smaller one arrives.
// The transaction carrying is_last ends the run and yields one result
// transaction (kth_magnitude, too_few); too_few is raised, with a zero
// magnitude, when the run held fewer than k samples.
// The rank k is written through the configuration channel while the block is
// idle; a write also abandons the run in progress, and input is refused while
// a write is offered. Reset sets k to one.
// Sequencing: an item that needs no rescan is taken directly. Filling the last
// free slot, or replacing the largest, starts a rescan of the kept slots, one
// slot a cycle, and no further sample is taken until the rescan ends. The
// store has one read port, which is why the rescan reads one slot at a time.
// A last item then goes through the emit state to load the output register.
// The output register lets the next run's samples be taken while a result
// waits; if the receiver stalls and a second result is ready, the block holds
// it and stops taking input until the first is accepted.
// Reset clears the controller, counters and output valid; store contents are
// left as they are and are never read before being written in a run.
module kth_smallest_magnitude_select (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ksms_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic                            is_last,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ksms_pkg::K_W-1:0]        k_count,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [ksms_pkg::SAMPLE_BITS-1:0]     kth_magnitude,
	output logic                                 too_few
);
	import ksms_pkg::*;

	ksms_cmd_t    cmd;
	ksms_status_t status;

	// The controller sequences accept, rescan and emit.
	ksms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.is_last   (is_last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the store, the running maximum and the result register.
	ksms_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.k_count       (k_count),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kth_magnitude (kth_magnitude),
		.too_few       (too_few)
	);

endmodule

`default_nettype wire
